// ===== rtl/mad_pkg.sv =====
// Shared types, constants and a helper function for the accelerometer moving
// average block with dead zone. No dependencies; every file but mad_ram imports it.
package mad_pkg;

    localparam int AXES        = 3;
    localparam int SAMPLE_W    = 8;
    localparam int SENSOR_W    = 3;
    localparam int ENTRY_W     = AXES * SAMPLE_W;
    localparam int IN_DATA_W   = 2 * AXES * SAMPLE_W;
    localparam int OUT_DATA_W  = AXES * SAMPLE_W;
    localparam int THRESHOLD_W = 8;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_WRITE = 6'b000010,
        ST_READ  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } mad_state_t;

    typedef struct packed {
        logic accept;
        logic write_entry;
        logic read_issue;
        logic div_step;
        logic out_load;
    } mad_cmd_t;

    typedef struct packed {
        logic in_range_in;
        logic in_range;
        logic read_last;
        logic div_last;
    } mad_status_t;

    // The 12-bit reading is {hi, lo[7:4]}; dividing it by 16 towards zero is the
    // signed high byte, plus one when it is negative and the dropped nibble is
    // not zero.
    function automatic logic signed [SAMPLE_W-1:0] axis_value(
        input logic [7:0] hi,
        input logic [7:0] lo
    );
        logic signed [SAMPLE_W-1:0] res;
        res = $signed(hi);
        if (hi[7] && (lo[7:4] != 4'd0)) begin
            res = res + 8'sd1;
        end
        return res;
    endfunction

endpackage

// ===== rtl/mad_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module mad_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 12,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mad_ctrl.sv =====
// Controller state machine for the moving average block: sequences write,
// window read, division and result hand-off. Depends on mad_pkg.
module mad_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  mad_pkg::mad_status_t status,
    output mad_pkg::mad_cmd_t    cmd
);
    import mad_pkg::*;

    mad_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.accept      = s_axis_tvalid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    // A sensor number beyond the configured count only echoes.
                    state_next = status.in_range_in ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: begin
                cmd.write_entry = 1'b1;
                state_next      = ST_READ;
            end
            ST_READ: begin
                cmd.read_issue = 1'b1;
                if (status.read_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_axis_tready))
        else $error("result word loaded over one still waiting");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_entry |-> status.in_range)
        else $error("window written for a sensor out of range");

    a_div_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && status.div_last) |=> (state_reg == ST_DONE))
        else $error("division did not hand over to the result stage");

    a_load_then_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/mad_dp.sv =====
// Datapath of the moving average block: input capture, window RAM with ring
// pointers, summation, dead zone and rounded division. Depends on mad_pkg, mad_ram.
module mad_dp #(
    parameter int WINDOW_SIZE = 3,
    parameter int NUM_SENSORS = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [mad_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [mad_pkg::SENSOR_W-1:0]   s_axis_tuser,
    output logic [mad_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [mad_pkg::SENSOR_W-1:0]   m_axis_tuser,
    input  logic                           cfg_wr_en,
    input  logic [mad_pkg::THRESHOLD_W-1:0] cfg_wr_data,
    input  mad_pkg::mad_cmd_t              cmd,
    output mad_pkg::mad_status_t           status
);
    import mad_pkg::*;

    localparam int DEPTH   = NUM_SENSORS * WINDOW_SIZE;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int SIDX_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int SUM_W   = $clog2(128 * WINDOW_SIZE) + 1;
    localparam int NUM_W   = $clog2(257 * WINDOW_SIZE + 1);
    localparam int CMP_W   = $clog2(255 * WINDOW_SIZE + 1);
    // Reciprocal of 2*WINDOW_SIZE, exact for every numerator below 2**NUM_W.
    localparam int SHIFT   = NUM_W + 5;
    localparam int RECIP   = (2 ** SHIFT + 2 * WINDOW_SIZE - 1) / (2 * WINDOW_SIZE);
    localparam int PROD_W  = NUM_W + SHIFT;

    logic [THRESHOLD_W-1:0]     thr_reg;
    logic [SENSOR_W-1:0]        sensor_reg;
    logic                       in_range_reg;
    logic [ADDR_W-1:0]          base_reg;
    logic signed [SAMPLE_W-1:0] val_reg [AXES];
    logic [SLOT_W-1:0]          slot_reg [NUM_SENSORS];
    logic                       full_reg [NUM_SENSORS];
    logic [SLOT_W-1:0]          rd_idx_reg;
    logic [SLOT_W-1:0]          pend_idx_reg;
    logic                       pend_reg;
    logic signed [SUM_W-1:0]    sum_reg [AXES];
    logic [1:0]                 ax_reg;
    logic signed [SAMPLE_W-1:0] avg_reg [AXES];
    logic [OUT_DATA_W-1:0]      out_data_reg;
    logic [SENSOR_W-1:0]        out_user_reg;

    logic [SIDX_W-1:0]          sidx;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ENTRY_W-1:0]         wr_data;
    logic [ENTRY_W-1:0]         rd_data;
    logic                       entry_valid;

    logic signed [SUM_W-1:0]    sum_sel;
    logic [SUM_W-1:0]           mag;
    logic [NUM_W-1:0]           numer;
    logic [PROD_W-1:0]          prod;
    logic [SAMPLE_W-1:0]        quot;
    logic [CMP_W-1:0]           thr_scaled;
    logic                       dead;
    logic signed [SAMPLE_W-1:0] avg_new;

    assign sidx    = sensor_reg[SIDX_W-1:0];
    assign wr_addr = base_reg + ADDR_W'(slot_reg[sidx]);
    assign rd_addr = base_reg + ADDR_W'(rd_idx_reg);
    assign wr_data = {val_reg[2], val_reg[1], val_reg[0]};

    mad_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_window_ram (
        .aclk   (aclk),
        .wr_en  (cmd.write_entry),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Slots fill in order from zero, so an entry has been written once the
    // ring has wrapped or its index lies below the write pointer.
    assign entry_valid = full_reg[sidx] || (pend_idx_reg < slot_reg[sidx]);

    assign status.in_range_in = (int'(s_axis_tuser) < NUM_SENSORS);
    assign status.in_range    = in_range_reg;
    assign status.read_last   = (rd_idx_reg == SLOT_W'(WINDOW_SIZE - 1));
    assign status.div_last    = (ax_reg == 2'(AXES - 1));

    // One axis a cycle: dead zone, then (2|sum| + W) / (2W), sign restored.
    always_comb begin
        sum_sel    = sum_reg[ax_reg];
        mag        = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
        numer      = NUM_W'({mag, 1'b0}) + NUM_W'(WINDOW_SIZE);
        prod       = PROD_W'(numer) * PROD_W'(RECIP);
        quot       = prod[SHIFT +: SAMPLE_W];
        thr_scaled = CMP_W'(thr_reg) * CMP_W'(WINDOW_SIZE);
        dead       = CMP_W'(mag) < thr_scaled;
        if (dead) begin
            avg_new = '0;
        end else if (sum_sel[SUM_W-1]) begin
            avg_new = -$signed(quot);
        end else begin
            avg_new = $signed(quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= '0;
            pend_reg <= 1'b0;
            for (int s = 0; s < NUM_SENSORS; s++) begin
                slot_reg[s] <= '0;
                full_reg[s] <= 1'b0;
            end
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            pend_reg <= cmd.read_issue;
            if (cmd.write_entry) begin
                if (slot_reg[sidx] == SLOT_W'(WINDOW_SIZE - 1)) begin
                    slot_reg[sidx] <= '0;
                    full_reg[sidx] <= 1'b1;
                end else begin
                    slot_reg[sidx] <= slot_reg[sidx] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= rd_idx_reg;
        if (cmd.accept) begin
            sensor_reg   <= s_axis_tuser;
            in_range_reg <= status.in_range_in;
            base_reg     <= ADDR_W'(int'(s_axis_tuser) * WINDOW_SIZE);
            rd_idx_reg   <= '0;
            ax_reg       <= '0;
            for (int a = 0; a < AXES; a++) begin
                val_reg[a] <= axis_value(s_axis_tdata[16*a +: 8], s_axis_tdata[16*a+8 +: 8]);
                sum_reg[a] <= '0;
                avg_reg[a] <= '0;
            end
        end else begin
            if (cmd.read_issue) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (pend_reg && entry_valid) begin
                for (int a = 0; a < AXES; a++) begin
                    sum_reg[a] <= sum_reg[a]
                        + SUM_W'($signed(rd_data[SAMPLE_W*a +: SAMPLE_W]));
                end
            end
            if (cmd.div_step) begin
                avg_reg[ax_reg] <= avg_new;
                ax_reg          <= ax_reg + 1'b1;
            end
        end
        if (cmd.out_load) begin
            out_data_reg <= {avg_reg[2], avg_reg[1], avg_reg[0]};
            out_user_reg <= sensor_reg;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;

endmodule

// ===== rtl/accel_moving_average_deadzone.sv =====
// Steps (W = WINDOW_SIZE): one RAM write, W registered window reads, a drain state,
// three divider steps, then the result stage until the output is free. Out of range
// sensors go straight to it; a new word is taken only when the last is through.
// The next word is accepted while a finished result still waits on the output.
// Reset (aresetn, synchronous, active low) empties the windows, clears the ring
// pointers and the threshold at once; no clearing pass is needed. Uses mad_pkg.
module accel_moving_average_deadzone #(
    parameter int WINDOW_SIZE = 3,
    parameter int NUM_SENSORS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x_hi, x_lo, y_hi, y_lo, z_hi, z_lo, from bit 0 up
    input  logic [mad_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // sensor_index
    input  logic [mad_pkg::SENSOR_W-1:0]    s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // x_avg, y_avg, z_avg, from bit 0 up
    output logic [mad_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // sensor_out
    output logic [mad_pkg::SENSOR_W-1:0]    m_axis_tuser,
    input  logic                            cfg_wr_en,
    // zero_threshold
    input  logic [mad_pkg::THRESHOLD_W-1:0] cfg_wr_data
);
    import mad_pkg::*;

    mad_cmd_t    cmd;
    mad_status_t status;

    mad_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .status       (status),
        .cmd          (cmd)
    );

    mad_dp #(
        .WINDOW_SIZE(WINDOW_SIZE),
        .NUM_SENSORS(NUM_SENSORS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
